// ===== sv/i2cms_pkg.sv =====
// Shared types and constants for the I2C master byte sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none
package i2cms_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] RESET_POLL_LIMIT = 8'd250;

   localparam logic [2:0] CMD_START     = 3'd0;
   localparam logic [2:0] CMD_STOP      = 3'd1;
   localparam logic [2:0] CMD_WRITE     = 3'd2;
   localparam logic [2:0] CMD_READ_ACK  = 3'd3;
   localparam logic [2:0] CMD_READ_NACK = 3'd4;

   localparam logic [2:0] HOLD_NONE  = 3'd0;
   localparam logic [2:0] HOLD_ACK   = 3'd1;
   localparam logic [2:0] HOLD_BIT   = 3'd2;
   localparam logic [2:0] HOLD_SETUP = 3'd4;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ
   } kind_type;

   // flag: ack timeout for a write, nack for a read
   typedef struct packed {
      kind_type                 kind;
      logic [BITS_PER_BYTE-1:0] data;
      logic                     flag;
   } op_type;

   typedef struct packed {
      logic                     scl;
      logic                     sda;
      logic                     released;
      logic [2:0]               hold;
      logic [BITS_PER_BYTE-1:0] rx;
      logic                     err;
      logic                     last;
   } phase_type;

endpackage
`default_nettype wire

// ===== sv/i2cms_front.sv =====
// Front end: holds the poll limit register, accepts and classifies commands.
// Depends on i2cms_pkg; feeds i2cms_queue.
`default_nettype none
module i2cms_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [7:0]           csr_wr_data,
   input  wire logic                 req_push,
   input  wire logic [2:0]           req_command,
   input  wire logic [7:0]           req_tx_byte,
   input  wire logic [7:0]           req_slave_bits,
   input  wire logic [7:0]           req_ack_polls,
   input  wire logic                 q_full,
   output      logic                 q_push,
   output      i2cms_pkg::op_type    q_op
);
   import i2cms_pkg::*;

   logic [7:0] limit_ff;
   logic [7:0] limit_in;
   logic       known;

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RESET_POLL_LIMIT;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      known       = 1'b1;
      q_op.kind   = KIND_START;
      q_op.data   = req_tx_byte;
      q_op.flag   = 1'b0;
      case (req_command)
         CMD_START: begin
            q_op.kind = KIND_START;
         end
         CMD_STOP: begin
            q_op.kind = KIND_STOP;
         end
         CMD_WRITE: begin
            q_op.kind = KIND_WRITE;
            q_op.flag = req_ack_polls > limit_ff;
         end
         CMD_READ_ACK, CMD_READ_NACK: begin
            q_op.kind = KIND_READ;
            q_op.data = req_slave_bits;
            q_op.flag = req_command == CMD_READ_NACK;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // drop unknown commands
   assign q_push = req_push && !q_full && known;

endmodule
`default_nettype wire

// ===== sv/i2cms_queue.sv =====
// Short command queue between the front end and the phase generator.
// Depends on i2cms_pkg.
`default_nettype none
module i2cms_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  i2cms_pkg::op_type      push_op,
   output      logic              full,
   input  wire logic              pop,
   output      logic              head_valid,
   output      i2cms_pkg::op_type head_op
);
   import i2cms_pkg::*;

   op_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_pop;

   assign full       = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_op    = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/i2cms_phase_gen.sv =====
// Back end: steps through the bus phases of the head command into a registered result
// slot, one a cycle unless the slot holds an unpopped phase. Depends on i2cms_pkg.
`default_nettype none
module i2cms_phase_gen (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  i2cms_pkg::op_type         head_op,
   output      logic                 head_pop,
   input  wire logic                 out_pop,
   output      logic                 out_valid,
   output      i2cms_pkg::phase_type out_phase
);
   import i2cms_pkg::*;

   localparam logic [BIT_IDX_W-1:0] BIT_TOP = BIT_IDX_W'(BITS_PER_BYTE - 1);

   typedef enum logic [1:0] {
      ST_FRESH,
      ST_BIT,
      ST_TAIL
   } state_type;

   state_type              state_ff, state_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [1:0]             sub_ff, sub_in;
   logic [1:0]             tail_ff, tail_in;
   logic                   valid_ff, valid_in;
   phase_type              phase_ff, phase_in;
   phase_type              ph;
   logic                   bit_mode;
   logic                   bit_val;
   logic [1:0]             sub_last;
   logic                   advance;

   assign bit_mode = (state_ff == ST_BIT) ||
                     (state_ff == ST_FRESH &&
                      (head_op.kind == KIND_WRITE || head_op.kind == KIND_READ));
   assign bit_val  = head_op.data[bit_ff];
   assign sub_last = (head_op.kind == KIND_WRITE) ? 2'd2 : 2'd1;
   assign advance  = head_valid && (!valid_ff || out_pop);
   assign head_pop = advance && ph.last;

   always_comb begin
      ph = '{scl: 1'b0, sda: 1'b1, released: 1'b0, hold: HOLD_NONE,
             rx: '0, err: 1'b0, last: 1'b0};
      case (head_op.kind)
         KIND_START: begin
            ph.scl  = tail_ff != 2'd2;
            ph.sda  = tail_ff == 2'd0;
            ph.hold = (tail_ff == 2'd2) ? HOLD_NONE : HOLD_SETUP;
            ph.last = tail_ff == 2'd2;
         end
         KIND_STOP: begin
            ph.scl  = tail_ff != 2'd0;
            ph.sda  = tail_ff != 2'd0;
            ph.hold = HOLD_SETUP;
            ph.last = tail_ff != 2'd0;
         end
         KIND_WRITE: begin
            if (bit_mode) begin
               ph.scl  = sub_ff == 2'd1;
               ph.sda  = bit_val;
               ph.hold = HOLD_BIT;
            end else if (tail_ff == 2'd0 || tail_ff == 2'd1) begin
               ph.scl      = tail_ff == 2'd1;
               ph.released = 1'b1;
               ph.hold     = HOLD_ACK;
            end else if (head_op.flag) begin
               // timeout: issue a stop
               ph.scl  = tail_ff == 2'd3;
               ph.sda  = tail_ff == 2'd3;
               ph.hold = HOLD_SETUP;
               ph.err  = 1'b1;
               ph.last = tail_ff == 2'd3;
            end else begin
               ph.released = 1'b1;
               ph.last     = 1'b1;
            end
         end
         KIND_READ: begin
            if (bit_mode) begin
               ph.scl      = sub_ff == 2'd1;
               ph.released = 1'b1;
               ph.hold     = (sub_ff == 2'd1) ? HOLD_ACK : HOLD_BIT;
            end else begin
               ph.scl  = tail_ff == 2'd1;
               ph.sda  = head_op.flag;
               ph.hold = (tail_ff == 2'd2) ? HOLD_NONE : HOLD_BIT;
               ph.last = tail_ff == 2'd2;
               ph.rx   = (tail_ff == 2'd2) ? head_op.data : '0;
            end
         end
         default: begin
            ph.last = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      sub_in   = sub_ff;
      tail_in  = tail_ff;
      valid_in = valid_ff && !out_pop;
      phase_in = phase_ff;
      if (advance) begin
         valid_in = 1'b1;
         phase_in = ph;
         if (ph.last) begin
            state_in = ST_FRESH;
            bit_in   = BIT_TOP;
            sub_in   = '0;
            tail_in  = '0;
         end else if (bit_mode) begin
            state_in = ST_BIT;
            if (sub_ff == sub_last) begin
               sub_in = '0;
               if (bit_ff == '0) begin
                  state_in = ST_TAIL;
                  bit_in   = BIT_TOP;
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end else begin
            state_in = ST_TAIL;
            tail_in  = tail_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FRESH;
         bit_ff   <= BIT_TOP;
         sub_ff   <= '0;
         tail_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         sub_ff   <= sub_in;
         tail_ff  <= tail_in;
         valid_ff <= valid_in;
      end
      phase_ff <= phase_in;
   end

   assign out_valid = valid_ff;
   assign out_phase = phase_ff;

endmodule
`default_nettype wire

// ===== sv/i2c_master_byte_sequencer.sv =====
// Top level of the I2C master byte sequencer.
// Depends on i2cms_pkg, i2cms_front, i2cms_queue and i2cms_phase_gen.
// Usage:
//   Command channel (req_): a queue input. A command is taken at a rising
//   edge with req_push high and req_full low. Commands 5 to 7 are taken and
//   dropped without any phase.
//   Phase channel (rsp_): a queue output. While rsp_empty is low the oldest
//   bus phase is on the rsp_ ports; it is taken at an edge with rsp_pop high.
//   rsp_last marks the final phase of a command.
//   Register: csr_wr_en with csr_wr_data sets the ack poll limit (reset 250);
//   write it only while the block is idle.
// Timing:
//   A command passes through the command queue before its first phase is
//   registered in the result slot. One phase is emitted a cycle while the
//   slot is free or popped. Phases per command: start 3, stop 2, read 19,
//   write 27 (28 on an ack timeout). A two-entry command queue lets the next
//   command be taken while the current one is still being emitted.
// Reset: clears the command queue, the result slot and the phase counters.
// Stall: with rsp_pop low the phase on the ports holds; once the queue fills,
//   req_full rises.
`default_nettype none
module i2c_master_byte_sequencer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   input  wire logic       req_push,
   output      logic       req_full,
   input  wire logic [2:0] req_command,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic [7:0] req_slave_bits,
   input  wire logic [7:0] req_ack_polls,
   output      logic       rsp_empty,
   input  wire logic       rsp_pop,
   output      logic       rsp_scl_level,
   output      logic       rsp_sda_level,
   output      logic       rsp_sda_released,
   output      logic [2:0] rsp_hold_units,
   output      logic [7:0] rsp_rx_byte,
   output      logic       rsp_ack_error,
   output      logic       rsp_last
);
   import i2cms_pkg::*;

   logic      q_push;
   op_type    q_op;
   logic      q_full;
   logic      head_valid;
   op_type    head_op;
   logic      head_pop;
   logic      out_valid;
   phase_type out_phase;

   i2cms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_push       (req_push),
      .req_command    (req_command),
      .req_tx_byte    (req_tx_byte),
      .req_slave_bits (req_slave_bits),
      .req_ack_polls  (req_ack_polls),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_op           (q_op)
   );

   i2cms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_op),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   i2cms_phase_gen u_phase_gen (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .head_pop   (head_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .out_phase  (out_phase)
   );

   assign req_full         = q_full;
   assign rsp_empty        = !out_valid;
   assign rsp_scl_level    = out_phase.scl;
   assign rsp_sda_level    = out_phase.sda;
   assign rsp_sda_released = out_phase.released;
   assign rsp_hold_units   = out_phase.hold;
   assign rsp_rx_byte      = out_phase.rx;
   assign rsp_ack_error    = out_phase.err;
   assign rsp_last         = out_phase.last;

endmodule
`default_nettype wire

// ===== sv/i2cms_checker.sv =====
// Port-level checks for the I2C master byte sequencer, bound to its top level.
// Depends on i2c_master_byte_sequencer.
`default_nettype none
module i2cms_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic       rsp_scl_level,
   input wire logic       rsp_sda_level,
   input wire logic       rsp_sda_released,
   input wire logic [2:0] rsp_hold_units,
   input wire logic [7:0] rsp_rx_byte,
   input wire logic       rsp_ack_error,
   input wire logic       rsp_last
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_scl_level) &&
      $stable(rsp_sda_level) && $stable(rsp_hold_units) && $stable(rsp_last))
      else $error("stalled beat changed");

   a_released_high: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_sda_released |-> rsp_sda_level)
      else $error("released SDA not high");

   a_error_is_stop: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_ack_error |->
      !rsp_sda_released && rsp_hold_units == 3'd4 && rsp_rx_byte == 8'd0)
      else $error("ack error outside a stop phase");

   a_last_high_is_stop: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last && rsp_scl_level |->
      rsp_sda_level && rsp_hold_units == 3'd4)
      else $error("final phase with SCL high is not a stop");

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_i2cms_checker (.*);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the I2C master byte sequencer: it drives bus commands,
// predicts every bus phase and compares each phase beat with the prediction.
// Depends on i2cms_pkg and i2c_master_byte_sequencer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cms_pkg::*;

   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_CAP     = 60;

   typedef struct {
      logic [2:0] command;
      logic [7:0] tx_byte;
      logic [7:0] slave_bits;
      logic [7:0] ack_polls;
      bit         drain_first;
   } bus_cmd_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [2:0] req_command = CMD_START;
   logic [7:0] req_tx_byte = '0;
   logic [7:0] req_slave_bits = '0;
   logic [7:0] req_ack_polls = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic       rsp_sda_released;
   logic [2:0] rsp_hold_units;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_error;
   logic       rsp_last;

   bus_cmd_type pending_cmds[$];
   bus_cmd_type cur_cmd;
   phase_type   bus_phases_due[$];
   logic [7:0]  poll_limit_model = RESET_POLL_LIMIT;
   int          mismatch_count = 0;
   int          send_gap = 0;
   int          pop_gap = 0;
   bit          send_calm = 1'b0;
   bit          pop_calm = 1'b0;
   int          idle_cycles = 0;

   i2c_master_byte_sequencer u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_tx_byte      (req_tx_byte),
      .req_slave_bits   (req_slave_bits),
      .req_ack_polls    (req_ack_polls),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_level    (rsp_sda_level),
      .rsp_sda_released (rsp_sda_released),
      .rsp_hold_units   (rsp_hold_units),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_ack_error    (rsp_ack_error),
      .rsp_last         (rsp_last)
   );

   always #1 clock = ~clock;

   function automatic void add_phase(logic scl, logic sda, logic rel, logic [2:0] hold,
                                     logic [7:0] rx, logic err, logic fin);
      phase_type p;
      p.scl      = scl;
      p.sda      = rel ? 1'b1 : sda;
      p.released = rel;
      p.hold     = hold;
      p.rx       = rx;
      p.err      = err;
      p.last     = fin;
      bus_phases_due.push_back(p);
   endfunction

   function automatic void plan_bus_phases(bus_cmd_type c);
      logic [7:0] sampled;
      logic       ack_level;
      sampled   = '0;
      ack_level = (c.command == CMD_READ_NACK);
      case (c.command)
         CMD_START: begin
            add_phase(1'b1, 1'b1, 1'b0, HOLD_SETUP, 8'h00, 1'b0, 1'b0);
            add_phase(1'b1, 1'b0, 1'b0, HOLD_SETUP, 8'h00, 1'b0, 1'b0);
            add_phase(1'b0, 1'b0, 1'b0, HOLD_NONE, 8'h00, 1'b0, 1'b1);
         end
         CMD_STOP: begin
            add_phase(1'b0, 1'b0, 1'b0, HOLD_SETUP, 8'h00, 1'b0, 1'b0);
            add_phase(1'b1, 1'b1, 1'b0, HOLD_SETUP, 8'h00, 1'b0, 1'b1);
         end
         CMD_WRITE: begin
            for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
               add_phase(1'b0, c.tx_byte[i], 1'b0, HOLD_BIT, 8'h00, 1'b0, 1'b0);
               add_phase(1'b1, c.tx_byte[i], 1'b0, HOLD_BIT, 8'h00, 1'b0, 1'b0);
               add_phase(1'b0, c.tx_byte[i], 1'b0, HOLD_BIT, 8'h00, 1'b0, 1'b0);
            end
            add_phase(1'b0, 1'b1, 1'b1, HOLD_ACK, 8'h00, 1'b0, 1'b0);
            add_phase(1'b1, 1'b1, 1'b1, HOLD_ACK, 8'h00, 1'b0, 1'b0);
            if (c.ack_polls > poll_limit_model) begin
               add_phase(1'b0, 1'b0, 1'b0, HOLD_SETUP, 8'h00, 1'b1, 1'b0);
               add_phase(1'b1, 1'b1, 1'b0, HOLD_SETUP, 8'h00, 1'b1, 1'b1);
            end else begin
               add_phase(1'b0, 1'b1, 1'b1, HOLD_NONE, 8'h00, 1'b0, 1'b1);
            end
         end
         CMD_READ_ACK, CMD_READ_NACK: begin
            for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
               add_phase(1'b0, 1'b1, 1'b1, HOLD_BIT, 8'h00, 1'b0, 1'b0);
               add_phase(1'b1, 1'b1, 1'b1, HOLD_ACK, 8'h00, 1'b0, 1'b0);
               sampled = {sampled[6:0], c.slave_bits[i]};
            end
            add_phase(1'b0, ack_level, 1'b0, HOLD_BIT, 8'h00, 1'b0, 1'b0);
            add_phase(1'b1, ack_level, 1'b0, HOLD_BIT, 8'h00, 1'b0, 1'b0);
            add_phase(1'b0, ack_level, 1'b0, HOLD_NONE, sampled, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic int rand_gap(bit calm);
      int r;
      r = int'($urandom_range(99));
      if (calm || r < 55)
         return 0;
      if (r < 92)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(6, 40));
   endfunction

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_push         <= 1'b0;
         poll_limit_model <= RESET_POLL_LIMIT;
         send_gap         = 0;
      end else begin
         if (csr_wr_en)
            poll_limit_model <= csr_wr_data;
         if (req_push && !req_full) begin
            plan_bus_phases(cur_cmd);
            send_gap = rand_gap(send_calm);
            if ($urandom_range(49) == 0)
               send_calm = !send_calm;
         end
         if (req_push && req_full) begin
            // hold the beat until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_cmds.size() != 0 &&
                      !(pending_cmds[0].drain_first && bus_phases_due.size() != 0)) begin
            cur_cmd = pending_cmds.pop_front();
            req_push       <= 1'b1;
            req_command    <= cur_cmd.command;
            req_tx_byte    <= cur_cmd.tx_byte;
            req_slave_bits <= cur_cmd.slave_bits;
            req_ack_polls  <= cur_cmd.ack_polls;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP)
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   // phase monitor
   always @(posedge clock) begin
      phase_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (bus_phases_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_CAP)
                  $display("%0t: phase expected none got scl %0d sda %0d hold %0d",
                           $time, rsp_scl_level, rsp_sda_level, rsp_hold_units);
            end else begin
               want = bus_phases_due.pop_front();
               check_field("scl_level", int'(want.scl), int'(rsp_scl_level));
               check_field("sda_level", int'(want.sda), int'(rsp_sda_level));
               check_field("sda_released", int'(want.released), int'(rsp_sda_released));
               check_field("hold_units", int'(want.hold), int'(rsp_hold_units));
               check_field("rx_byte", int'(want.rx), int'(rsp_rx_byte));
               check_field("ack_error", int'(want.err), int'(rsp_ack_error));
               check_field("last", int'(want.last), int'(rsp_last));
            end
            pop_gap = rand_gap(pop_calm);
            if ($urandom_range(49) == 0)
               pop_calm = !pop_calm;
         end else if (pop_gap > 0) begin
            pop_gap--;
         end
         rsp_pop <= (pop_gap == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void queue_cmd(logic [2:0] command, logic [7:0] tx, logic [7:0] sb,
                                     logic [7:0] polls, bit drain);
      bus_cmd_type c;
      c.command     = command;
      c.tx_byte     = tx;
      c.slave_bits  = sb;
      c.ack_polls   = polls;
      c.drain_first = drain;
      pending_cmds.push_back(c);
   endfunction

   function automatic logic [7:0] pick_polls(logic [7:0] limit);
      int p;
      if ($urandom_range(1) == 0)
         return 8'($urandom_range(255));
      p = int'(limit) + int'($urandom_range(4)) - 2;
      if (p < 0)
         p = 0;
      if (p > 255)
         p = 255;
      return p[7:0];
   endfunction

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_cmds.size() != 0 || req_push || bus_phases_due.size() != 0);
   endtask

   task automatic write_poll_limit(logic [7:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic load_transactions(int target, logic [7:0] limit);
      int valid;
      int txn;
      int n;
      logic [2:0] cmd;
      valid = 0;
      txn   = 0;
      while (valid < target) begin
         if ($urandom_range(99) < 15) begin
            cmd = 3'($urandom_range(CMD_START, CMD_LAST_UNUSED));
            queue_cmd(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      pick_polls(limit), 1'b0);
            if (cmd < CMD_FIRST_UNUSED)
               valid++;
         end else begin
            queue_cmd(CMD_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), txn % 8 == 2);
            queue_cmd(CMD_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      pick_polls(limit), 1'b0);
            n = int'($urandom_range(1, 4));
            repeat (n) begin
               case ($urandom_range(2))
                  0: cmd = CMD_WRITE;
                  1: cmd = CMD_READ_ACK;
                  default: cmd = CMD_READ_NACK;
               endcase
               queue_cmd(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         pick_polls(limit), 1'b0);
            end
            queue_cmd(CMD_STOP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'b0);
            valid += n + 3;
            txn++;
         end
      end
   endtask

   initial begin
      logic [7:0] mid_limit;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_cmd(CMD_START, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(CMD_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0);
      queue_cmd(CMD_WRITE, 8'hFF, 8'h00, 8'd250, 1'b0);
      queue_cmd(CMD_WRITE, 8'hA5, 8'h5A, 8'd251, 1'b0);
      queue_cmd(CMD_WRITE, 8'h5A, 8'hA5, 8'hFF, 1'b0);
      queue_cmd(CMD_READ_ACK, 8'hFF, 8'h00, 8'hFF, 1'b0);
      queue_cmd(CMD_READ_ACK, 8'h00, 8'hFF, 8'h00, 1'b0);
      queue_cmd(CMD_READ_NACK, 8'h5A, 8'hA5, 8'h00, 1'b0);
      queue_cmd(CMD_READ_NACK, 8'hA5, 8'h5A, 8'hFF, 1'b0);
      queue_cmd(CMD_STOP, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(CMD_FIRST_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_cmd(CMD_FIRST_UNUSED + 3'd1, 8'h5A, 8'hA5, 8'h01, 1'b0);
      queue_cmd(CMD_LAST_UNUSED, 8'hA5, 8'h5A, 8'hFE, 1'b0);
      queue_cmd(CMD_STOP, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_cmd(CMD_START, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_cmd(CMD_START, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(CMD_WRITE, 8'h01, 8'h80, 8'd249, 1'b0);
      queue_cmd(CMD_READ_ACK, 8'h80, 8'h80, 8'd251, 1'b0);
      queue_cmd(CMD_STOP, 8'h00, 8'h00, 8'h00, 1'b0);

      write_poll_limit(8'd0);
      queue_cmd(CMD_WRITE, 8'hC3, 8'h00, 8'd0, 1'b0);
      queue_cmd(CMD_WRITE, 8'h3C, 8'h00, 8'd1, 1'b0);
      load_transactions(60, 8'd0);

      write_poll_limit(8'd255);
      queue_cmd(CMD_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b0);
      load_transactions(60, 8'd255);

      mid_limit = 8'($urandom_range(1, 254));
      write_poll_limit(mid_limit);
      load_transactions(60, mid_limit);

      write_poll_limit(RESET_POLL_LIMIT);
      load_transactions(60, RESET_POLL_LIMIT);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/i2cms_pkg.sv
sv/i2cms_front.sv
sv/i2cms_queue.sv
sv/i2cms_phase_gen.sv
sv/i2c_master_byte_sequencer.sv
sv/i2cms_checker.sv
test/tb.sv
